// File: rtl/core/priority_task_list_scheduler_defines.svh
// Assertion macros for the priority task list scheduler.
// Used by the top level; expects signals clk and rst in scope.
`ifndef PRIORITY_TASK_LIST_SCHEDULER_DEFINES_SVH
`define PRIORITY_TASK_LIST_SCHEDULER_DEFINES_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define PTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define PTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ptl_pkg.sv
// Shared types and codes of the priority task list scheduler.
// No dependencies.
package ptl_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_DEL    = 2'd1;
  localparam logic [1:0] REQ_STEP   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] priority_req;
    logic [15:0] task_tag;
    logic [4:0]  slot;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  out_slot;
    logic [15:0] out_tag;
  } response_t;

  // Write enables of the task table, one per field group.
  typedef struct packed {
    logic link_next;
    logic link_prev;
    logic info;
    logic defer;
  } tbl_wen_t;

endpackage

// File: rtl/core/ptl_stream_if.sv
// Valid/ready stream channel used for requests and responses.
// Payload type is supplied by the instantiating level.
interface ptl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/ptl_table.sv
// Per-slot task table: links, priority, tag and deferred mark.
// One write port and one shared read port with registered read data; uses ptl_pkg.
module ptl_table #(
  parameter int MAX_TASKS = 32,
  parameter int IW = 5,
  parameter int LW = 6
) (
  input  logic                clk,
  input  logic [IW-1:0]       rd_addr,
  input  logic [IW-1:0]       wr_addr,
  input  ptl_pkg::tbl_wen_t   wen,
  input  logic [LW-1:0]       wr_next,
  input  logic [LW-1:0]       wr_prev,
  input  logic [15:0]         wr_prio,
  input  logic [15:0]         wr_handle,
  input  logic                wr_def,
  output logic [LW-1:0]       rd_next,
  output logic [LW-1:0]       rd_prev,
  output logic [15:0]         rd_prio,
  output logic [15:0]         rd_handle,
  output logic                rd_def
);

  logic [LW-1:0] next_mem   [MAX_TASKS];
  logic [LW-1:0] prev_mem   [MAX_TASKS];
  logic [15:0]   prio_mem   [MAX_TASKS];
  logic [15:0]   handle_mem [MAX_TASKS];
  logic          def_mem    [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (wen.link_next) next_mem[wr_addr] <= wr_next;
    if (wen.link_prev) prev_mem[wr_addr] <= wr_prev;
    if (wen.info) begin
      prio_mem[wr_addr]   <= wr_prio;
      handle_mem[wr_addr] <= wr_handle;
    end
    if (wen.defer) def_mem[wr_addr] <= wr_def;
    rd_next   <= next_mem[rd_addr];
    rd_prev   <= prev_mem[rd_addr];
    rd_prio   <= prio_mem[rd_addr];
    rd_handle <= handle_mem[rd_addr];
    rd_def    <= def_mem[rd_addr];
  end

endmodule

// File: rtl/core/priority_task_list_scheduler.sv
// Top level of the priority task list scheduler: sequencer, free stack, list registers.
// Depends on ptl_pkg, ptl_stream_if, ptl_table and the assertion macro header.
//
// The block keeps a table of MAX_TASKS task slots. Requests arrive on the req
// channel and every request gives exactly one transaction on the rsp channel.
// An add takes a slot from the free stack and links it into a list sorted by
// ascending priority (ties keep insertion order). A delete unlinks a slot and
// pushes it back on the free stack. A step walks the current run pass and
// returns the next task, skipping and re-enabling tasks marked deferred, or
// reports that the pass is done.
// An add walks the sorted list one entry per cycle through the single read
// port of the task table to find its place. A delete passes through S_DEL1
// and S_DEL2, and a step reads one more entry per deferred task skipped. A step
// at the end of the pass, a full table, a bad slot or an unused request code
// answer directly from the idle state.
// The block takes one request at a time; req.ready is high only in the idle
// state while the response register is empty or being drained.
// Reset is synchronous and leaves an empty list and a full free stack at once;
// no clearing pass is needed. When the receiver stalls, the response holds in
// its register and no further request is taken.
`include "priority_task_list_scheduler_defines.svh"

module priority_task_list_scheduler #(
  parameter int MAX_TASKS = 32
) (
  input logic         clk,
  input logic         rst,
  ptl_stream_if.sink   req,
  ptl_stream_if.source rsp
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] END_MARK = LW'(MAX_TASKS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ASLOT = 4'd1;
  localparam logic [3:0] S_AWALK = 4'd2;
  localparam logic [3:0] S_INS1 = 4'd3;
  localparam logic [3:0] S_INS2 = 4'd4;
  localparam logic [3:0] S_INS3 = 4'd5;
  localparam logic [3:0] S_APP1 = 4'd6;
  localparam logic [3:0] S_APP2 = 4'd7;
  localparam logic [3:0] S_DEL1 = 4'd8;
  localparam logic [3:0] S_DEL2 = 4'd9;
  localparam logic [3:0] S_STEP = 4'd10;

  logic [3:0]          state;
  logic [LW-1:0]       fp;          // free stack pointer, counts slots in use
  logic [LW-1:0]       head;
  logic [LW-1:0]       tail;
  logic [LW-1:0]       cursor;
  logic [LW-1:0]       running;
  logic                in_pass;
  logic [MAX_TASKS-1:0] in_use;
  logic [MAX_TASKS-1:0] fs_valid;   // free stack entry written since reset
  logic [LW-1:0]       cur;         // slot being worked on
  logic [IW-1:0]       s_reg;       // slot taken by the current add
  logic [LW-1:0]       p_reg;
  logic [LW-1:0]       n_reg;
  logic [15:0]         pri_reg;
  logic [15:0]         tag_reg;
  logic                out_valid;
  ptl_pkg::response_t  out_data;

  // Free stack memory; an entry never written reads as its own index.
  logic [IW-1:0]       fs_mem [MAX_TASKS];
  logic [IW-1:0]       fs_rd;

  // Task table ports.
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       tw_addr;
  ptl_pkg::tbl_wen_t   tw_wen;
  logic [LW-1:0]       tw_next;
  logic [LW-1:0]       tw_prev;
  logic                tw_def;
  logic [LW-1:0]       rd_next;
  logic [LW-1:0]       rd_prev;
  logic [15:0]         rd_prio;
  logic [15:0]         rd_handle;
  logic                rd_def;

  logic                accept;
  logic [IW-1:0]       fp_idx;
  logic [LW-1:0]       fp_dec;
  logic [IW-1:0]       new_slot;
  logic [LW-1:0]       step_c;
  logic [IW-1:0]       slot_idx;
  logic                slot_ok;
  logic                defer_bit;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign fp_idx    = fp[IW-1:0];
  assign fp_dec    = fp - LW'(1);
  assign new_slot  = fs_valid[fp_idx] ? fs_rd : fp_idx;
  assign step_c    = in_pass ? cursor : head;
  assign slot_idx  = IW'(req.data.slot);
  assign slot_ok   = (32'(req.data.slot) < MAX_TASKS) && in_use[slot_idx];
  // The table read issued at accept returns the running task's priority here.
  assign defer_bit = in_pass && (running < END_MARK) && (rd_prio <= pri_reg);

  ptl_table #(
    .MAX_TASKS(MAX_TASKS),
    .IW(IW),
    .LW(LW)
  ) u_table (
    .clk(clk),
    .rd_addr(rd_addr),
    .wr_addr(tw_addr),
    .wen(tw_wen),
    .wr_next(tw_next),
    .wr_prev(tw_prev),
    .wr_prio(pri_reg),
    .wr_handle(tag_reg),
    .wr_def(tw_def),
    .rd_next(rd_next),
    .rd_prev(rd_prev),
    .rd_prio(rd_prio),
    .rd_handle(rd_handle),
    .rd_def(rd_def)
  );

  // Table address and write control for each sequencer step.
  always_comb begin
    rd_addr = '0;
    tw_addr = '0;
    tw_wen  = '0;
    tw_next = END_MARK;
    tw_prev = END_MARK;
    tw_def  = 1'b0;
    case (state)
      S_IDLE: begin
        case (req.data.req_type)
          ptl_pkg::REQ_ADD:  rd_addr = running[IW-1:0];
          ptl_pkg::REQ_DEL:  rd_addr = slot_idx;
          ptl_pkg::REQ_STEP: rd_addr = step_c[IW-1:0];
          default:           rd_addr = '0;
        endcase
      end
      S_ASLOT: begin
        tw_addr      = new_slot;
        tw_wen.info  = 1'b1;
        tw_wen.defer = 1'b1;
        tw_def       = defer_bit;
        rd_addr      = head[IW-1:0];
      end
      S_AWALK: rd_addr = rd_next[IW-1:0];
      S_INS1: begin
        tw_addr          = s_reg;
        tw_wen.link_next = 1'b1;
        tw_wen.link_prev = 1'b1;
        tw_next          = cur;
        tw_prev          = p_reg;
      end
      S_INS2: begin
        tw_addr          = cur[IW-1:0];
        tw_wen.link_prev = 1'b1;
        tw_prev          = LW'(s_reg);
      end
      S_INS3: begin
        tw_addr          = p_reg[IW-1:0];
        tw_wen.link_next = (p_reg < END_MARK);
        tw_next          = LW'(s_reg);
      end
      S_APP1: begin
        tw_addr          = s_reg;
        tw_wen.link_next = 1'b1;
        tw_wen.link_prev = 1'b1;
        tw_next          = END_MARK;
        tw_prev          = tail;
      end
      S_APP2: begin
        tw_addr          = tail[IW-1:0];
        tw_wen.link_next = (tail < END_MARK);
        tw_next          = LW'(s_reg);
      end
      S_DEL1: begin
        tw_addr          = rd_prev[IW-1:0];
        tw_wen.link_next = (rd_prev < END_MARK);
        tw_next          = rd_next;
      end
      S_DEL2: begin
        tw_addr          = n_reg[IW-1:0];
        tw_wen.link_prev = (n_reg < END_MARK);
        tw_prev          = p_reg;
      end
      S_STEP: begin
        // A deferred task is skipped once and its mark is cleared.
        tw_addr      = cur[IW-1:0];
        tw_wen.defer = rd_def;
        tw_def       = 1'b0;
        rd_addr      = rd_next[IW-1:0];
      end
      default: rd_addr = '0;
    endcase
  end

  // Free stack storage: pushed on a delete, read at the pointer every cycle.
  always_ff @(posedge clk) begin
    if (state == S_DEL1) fs_mem[fp_dec[IW-1:0]] <= cur[IW-1:0];
    fs_rd <= fs_mem[fp_idx];
  end

  // Sequencer and list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fp        <= '0;
      head      <= END_MARK;
      tail      <= END_MARK;
      cursor    <= END_MARK;
      running   <= END_MARK;
      in_pass   <= 1'b0;
      in_use    <= '0;
      fs_valid  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            pri_reg <= req.data.priority_req;
            tag_reg <= req.data.task_tag;
            case (req.data.req_type)
              ptl_pkg::REQ_ADD: begin
                if (fp == END_MARK) begin
                  out_valid <= 1'b1;
                  out_data  <= '{status: ptl_pkg::ST_FULL, out_slot: '0, out_tag: '0};
                end else begin
                  state <= S_ASLOT;
                end
              end
              ptl_pkg::REQ_DEL: begin
                if (!slot_ok) begin
                  out_valid <= 1'b1;
                  out_data  <= '{status: ptl_pkg::ST_BAD, out_slot: req.data.slot,
                                 out_tag: '0};
                end else begin
                  cur   <= LW'(slot_idx);
                  state <= S_DEL1;
                end
              end
              ptl_pkg::REQ_STEP: begin
                if (step_c >= END_MARK) begin
                  in_pass   <= 1'b0;
                  cursor    <= END_MARK;
                  running   <= END_MARK;
                  out_valid <= 1'b1;
                  out_data  <= '{status: ptl_pkg::ST_DONE, out_slot: '0, out_tag: '0};
                end else begin
                  in_pass <= 1'b1;
                  cur     <= step_c;
                  state   <= S_STEP;
                end
              end
              default: begin
                out_valid <= 1'b1;
                out_data  <= '{status: ptl_pkg::ST_OK, out_slot: '0, out_tag: '0};
              end
            endcase
          end
        end
        S_ASLOT: begin
          s_reg            <= new_slot;
          fp               <= fp + LW'(1);
          in_use[new_slot] <= 1'b1;
          cur              <= head;
          state            <= (head < END_MARK) ? S_AWALK : S_APP1;
        end
        S_AWALK: begin
          // Insert before the first task of strictly higher priority value.
          if (rd_prio > pri_reg) begin
            p_reg <= rd_prev;
            state <= S_INS1;
          end else if (rd_next < END_MARK) begin
            cur <= rd_next;
          end else begin
            state <= S_APP1;
          end
        end
        S_INS1: begin
          if (cursor == cur) cursor <= LW'(s_reg);
          state <= S_INS2;
        end
        S_INS2: state <= S_INS3;
        S_INS3: begin
          if (p_reg >= END_MARK) head <= LW'(s_reg);
          out_valid <= 1'b1;
          out_data  <= '{status: ptl_pkg::ST_OK, out_slot: 5'(s_reg), out_tag: '0};
          state     <= S_IDLE;
        end
        S_APP1: begin
          if (cursor == END_MARK) cursor <= LW'(s_reg);
          state <= S_APP2;
        end
        S_APP2: begin
          if (tail >= END_MARK) head <= LW'(s_reg);
          tail      <= LW'(s_reg);
          out_valid <= 1'b1;
          out_data  <= '{status: ptl_pkg::ST_OK, out_slot: 5'(s_reg), out_tag: '0};
          state     <= S_IDLE;
        end
        S_DEL1: begin
          p_reg <= rd_prev;
          n_reg <= rd_next;
          if (cursor == cur) cursor <= rd_next;
          // Both list ends move at the same edge so they never disagree.
          if (rd_prev >= END_MARK) head <= rd_next;
          if (rd_next >= END_MARK) tail <= rd_prev;
          if (running == cur) running <= END_MARK;
          in_use[cur[IW-1:0]]   <= 1'b0;
          fs_valid[fp_dec[IW-1:0]] <= 1'b1;
          fp    <= fp_dec;
          state <= S_DEL2;
        end
        S_DEL2: begin
          out_valid <= 1'b1;
          out_data  <= '{status: ptl_pkg::ST_OK, out_slot: 5'(cur), out_tag: '0};
          state     <= S_IDLE;
        end
        S_STEP: begin
          cursor <= rd_next;
          if (!rd_def) begin
            running   <= cur;
            out_valid <= 1'b1;
            out_data  <= '{status: ptl_pkg::ST_OK, out_slot: 5'(cur), out_tag: rd_handle};
            state     <= S_IDLE;
          end else if (rd_next < END_MARK) begin
            cur <= rd_next;
          end else begin
            in_pass   <= 1'b0;
            cursor    <= END_MARK;
            running   <= END_MARK;
            out_valid <= 1'b1;
            out_data  <= '{status: ptl_pkg::ST_DONE, out_slot: '0, out_tag: '0};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The free stack pointer always equals the number of slots in use.
  `PTL_ASSERT_NOW(a_fp_count, 1'b1, $countones(in_use) == fp, "free pointer out of step")
  // The list is empty at both ends or at neither.
  `PTL_ASSERT_NOW(a_ends, 1'b1, (head == END_MARK) == (tail == END_MARK), "list ends disagree")
  // A request is never taken while an undelivered response would be lost.
  `PTL_ASSERT_NOW(a_rsp_room, accept, !rsp.valid || rsp.ready, "response overwritten")
  // Every accepted request leaves the idle state or answers at once.
  `PTL_ASSERT_NEXT(a_progress, accept, (state != S_IDLE) || rsp.valid, "request dropped")

endmodule
